@@ rtl/smsbfp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SMS PDU body field parser package
// Shared types and constants: parse states, field labels, status codes.
// ----------------------------------------------------------------------------
package smsbfp_pkg;

    localparam int unsigned MAX_BODY_BYTES = 4096;

    localparam int unsigned BYTE_CNT_W = 16;
    localparam logic [BYTE_CNT_W-1:0] LAST_BYTE_INDEX = BYTE_CNT_W'(MAX_BODY_BYTES - 1);
    localparam logic [BYTE_CNT_W-1:0] BYTE_CNT_MAX = '1;

    localparam logic [15:0] PAYLOAD_TAG_RESET = 16'd1060;

    // field labels
    localparam logic [4:0] FID_SERVICE_TYPE = 5'd0;
    localparam logic [4:0] FID_SRC_DIGITS   = 5'd3;
    localparam logic [4:0] FID_DST_DIGITS   = 5'd6;
    localparam logic [4:0] FID_ESM_CLASS    = 5'd7;
    localparam logic [4:0] FID_SCHED_TIME   = 5'd10;
    localparam logic [4:0] FID_VALIDITY     = 5'd11;
    localparam logic [4:0] FID_REG_DELIVERY = 5'd12;
    localparam logic [4:0] FID_DATA_CODING  = 5'd14;
    localparam logic [4:0] FID_DEF_MSG_ID   = 5'd15;
    localparam logic [4:0] FID_LENGTH       = 5'd16;
    localparam logic [4:0] FID_TEXT         = 5'd17;
    localparam logic [4:0] FID_REC_TAG      = 5'd18;
    localparam logic [4:0] FID_REC_LEN      = 5'd19;
    localparam logic [4:0] FID_REC_VAL      = 5'd20;
    localparam logic [4:0] FID_TRAILING     = 5'd21;

    // status codes
    localparam logic [1:0] STAT_BUSY        = 2'd0;
    localparam logic [1:0] STAT_OK          = 2'd1;
    localparam logic [1:0] STAT_TRUNC_FIXED = 2'd2;
    localparam logic [1:0] STAT_TRUNC_VALUE = 2'd3;

    typedef enum logic [6:0] {
        ST_FIXED   = 7'b0000001,
        ST_LENGTH  = 7'b0000010,
        ST_TEXT    = 7'b0000100,
        ST_REC_HDR = 7'b0001000,
        ST_REC_VAL = 7'b0010000,
        ST_TRAIL   = 7'b0100000,
        ST_DONE    = 7'b1000000
    } parse_state_t;

endpackage
`default_nettype wire

@@ rtl/sms_pdu_body_field_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SMS PDU body field parser
// Labels each body byte with its field, marks field ends, reports truncation.
// ----------------------------------------------------------------------------
// Output: each accepted byte appears in the output register in the cycle after its transaction.
// Throughput: 1 byte per cycle; the whole parse step sits between the state
// registers and the output register, so a byte is taken on every cycle in
// which the output register is empty or being drained.
// Reset: rst_n clears the parser to the service type field in short-message
// layout, empties the output register and loads payload tag 1060.
module sms_pdu_body_field_parser
    import smsbfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,     // payload_tag
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,    // [7:0] data_byte
    input  wire logic        s_axis_tlast,    // last_byte
    input  wire logic [1:0]  s_axis_tuser,    // [0] first_byte, [1] layout
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,    // [7:0] value, [9:8] status, [15:10] zero
    output logic             m_axis_tlast,    // field_end
    output logic [4:0]       m_axis_tuser     // [4:0] field_id
);

    logic [15:0]           payload_tag_reg;
    parse_state_t          st_reg, st_next;
    logic [3:0]            fidx_reg, fidx_next;
    logic                  layout_reg, layout_next;
    logic [15:0]           rem_reg, rem_next;
    logic [15:0]           tag_reg, tag_next;
    logic [1:0]            hidx_reg, hidx_next;
    logic                  is_pay_reg, is_pay_next;
    logic [BYTE_CNT_W-1:0] bcnt_reg, bcnt_next;

    logic                  m_valid_reg;
    logic [7:0]            m_value_reg, m_value_next;
    logic [1:0]            m_status_reg, m_status_next;
    logic                  m_fend_reg, m_fend_next;
    logic [4:0]            m_fid_reg, m_fid_next;

    logic                  in_fire;
    logic                  first;
    logic [7:0]            d;
    parse_state_t          st_cur;
    logic [3:0]            fidx_cur;
    logic                  layout_cur;
    logic [15:0]           rem_cur;
    logic [15:0]           tag_cur;
    logic [1:0]            hidx_cur;
    logic                  is_pay_cur;
    logic [BYTE_CNT_W-1:0] bcnt_cur;
    logic                  last_eff;
    logic [1:0]            endstat;
    logic [15:0]           rem_dec;
    logic [15:0]           rem_shift;
    logic                  is_string;
    logic [4:0]            fid_cur;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign first         = s_axis_tuser[0];
    assign d             = s_axis_tdata;

    always_comb
    begin
        // restart on first byte
        st_cur     = first ? ST_FIXED : st_reg;
        fidx_cur   = first ? 4'd0 : fidx_reg;
        layout_cur = first ? s_axis_tuser[1] : layout_reg;
        rem_cur    = first ? 16'd0 : rem_reg;
        tag_cur    = first ? 16'd0 : tag_reg;
        hidx_cur   = first ? 2'd0 : hidx_reg;
        is_pay_cur = first ? 1'b0 : is_pay_reg;
        bcnt_cur   = first ? '0 : bcnt_reg;

        fid_cur    = {1'b0, fidx_cur};
        rem_dec    = rem_cur - 16'd1;
        rem_shift  = {rem_cur[7:0], d};
        is_string  = (fid_cur == FID_SERVICE_TYPE) || (fid_cur == FID_SRC_DIGITS) ||
                     (fid_cur == FID_DST_DIGITS) || (fid_cur == FID_SCHED_TIME) ||
                     (fid_cur == FID_VALIDITY);

        st_next     = st_cur;
        fidx_next   = fidx_cur;
        layout_next = layout_cur;
        rem_next    = rem_cur;
        tag_next    = tag_cur;
        hidx_next   = hidx_cur;
        is_pay_next = is_pay_cur;
        bcnt_next   = bcnt_cur;

        m_value_next  = d;
        m_fid_next    = FID_TRAILING;
        m_fend_next   = 1'b0;
        m_status_next = STAT_BUSY;
        endstat       = STAT_OK;
        last_eff      = 1'b0;

        if (st_cur != ST_DONE)
        begin
            last_eff = s_axis_tlast || (bcnt_cur >= LAST_BYTE_INDEX);
            if (bcnt_cur != BYTE_CNT_MAX)
            begin
                bcnt_next = bcnt_cur + 1'b1;
            end

            case (st_cur)
                ST_FIXED:
                begin
                    m_fid_next = fid_cur;
                    endstat    = STAT_TRUNC_FIXED;
                    if (!is_string || (d == 8'd0))
                    begin
                        m_fend_next = 1'b1;
                        // advance to the next fixed field, or to the length or record header state after the last one
                        if (layout_cur && (fid_cur == FID_DATA_CODING))
                        begin
                            st_next = ST_REC_HDR;
                            endstat = STAT_OK;
                        end
                        else if (fid_cur == FID_DEF_MSG_ID)
                        begin
                            st_next = ST_LENGTH;
                        end
                        else if (layout_cur && (fid_cur == FID_ESM_CLASS))
                        begin
                            fidx_next = FID_REG_DELIVERY[3:0];
                        end
                        else if (layout_cur && (fid_cur == FID_REG_DELIVERY))
                        begin
                            fidx_next = FID_DATA_CODING[3:0];
                        end
                        else
                        begin
                            fidx_next = fidx_cur + 4'd1;
                        end
                    end
                end
                ST_LENGTH:
                begin
                    m_fid_next  = FID_LENGTH;
                    m_fend_next = 1'b1;
                    rem_next    = {8'd0, d};
                    if (d != 8'd0)
                    begin
                        st_next = ST_TEXT;
                        endstat = STAT_TRUNC_VALUE;
                    end
                    else
                    begin
                        st_next = ST_TRAIL;
                    end
                end
                ST_TEXT:
                begin
                    m_fid_next = FID_TEXT;
                    rem_next   = rem_dec;
                    if (rem_dec == 16'd0)
                    begin
                        m_fend_next = 1'b1;
                        st_next     = ST_TRAIL;
                    end
                    else
                    begin
                        endstat = STAT_TRUNC_VALUE;
                    end
                end
                ST_REC_HDR:
                begin
                    m_fid_next  = hidx_cur[1] ? FID_REC_LEN : FID_REC_TAG;
                    m_fend_next = hidx_cur[0];
                    hidx_next   = hidx_cur + 2'd1;
                    case (hidx_cur)
                        2'd0:
                        begin
                            tag_next = {8'd0, d};
                            rem_next = 16'd0;
                        end
                        2'd1:
                        begin
                            tag_next = {tag_cur[7:0], d};
                        end
                        default:
                        begin
                            rem_next = rem_shift;
                        end
                    endcase
                    if (hidx_cur == 2'd3)
                    begin
                        is_pay_next = (tag_cur == payload_tag_reg);
                        if (rem_shift != 16'd0)
                        begin
                            st_next = ST_REC_VAL;
                            endstat = STAT_TRUNC_VALUE;
                        end
                    end
                end
                ST_REC_VAL:
                begin
                    m_fid_next = is_pay_cur ? FID_TEXT : FID_REC_VAL;
                    rem_next   = rem_dec;
                    if (rem_dec == 16'd0)
                    begin
                        m_fend_next = 1'b1;
                        st_next     = ST_REC_HDR;
                        hidx_next   = 2'd0;
                    end
                    else
                    begin
                        endstat = STAT_TRUNC_VALUE;
                    end
                end
                default:
                begin
                    st_next = ST_TRAIL;
                end
            endcase

            if (last_eff)
            begin
                st_next       = ST_DONE;
                m_status_next = endstat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            payload_tag_reg <= PAYLOAD_TAG_RESET;
        end
        else if (cfg_wr_en)
        begin
            payload_tag_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_FIXED;
            fidx_reg   <= 4'd0;
            layout_reg <= 1'b0;
            rem_reg    <= 16'd0;
            tag_reg    <= 16'd0;
            hidx_reg   <= 2'd0;
            is_pay_reg <= 1'b0;
            bcnt_reg   <= '0;
        end
        else if (in_fire)
        begin
            st_reg     <= st_next;
            fidx_reg   <= fidx_next;
            layout_reg <= layout_next;
            rem_reg    <= rem_next;
            tag_reg    <= tag_next;
            hidx_reg   <= hidx_next;
            is_pay_reg <= is_pay_next;
            bcnt_reg   <= bcnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            m_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            m_value_reg  <= m_value_next;
            m_status_reg <= m_status_next;
            m_fend_reg   <= m_fend_next;
            m_fid_reg    <= m_fid_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'd0, m_status_reg, m_value_reg};
    assign m_axis_tlast  = m_fend_reg;
    assign m_axis_tuser  = m_fid_reg;

    a_last_ends_body: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_axis_tlast) |=> (st_reg == ST_DONE))
        else $error("body did not end after final byte");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while output stalled");

    a_record_no_fixed_trunc: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (m_fid_reg == FID_REC_VAL)) |-> (m_status_reg != STAT_TRUNC_FIXED))
        else $error("record value reported as fixed-field truncation");

    a_trailing_no_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (m_fid_reg == FID_TRAILING)) |-> !m_fend_reg)
        else $error("field end on trailing byte");

endmodule
`default_nettype wire
